// ===== sv/ssh_packet_deframer_top_defines.svh =====
// Assertion macros shared by the deframer modules.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef SSH_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define SSH_PACKET_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/spd_pkg.sv =====
`timescale 1ns / 1ps

package spd_pkg;

   // Framing limits.
   localparam logic [15:0] ABS_MAX_PACKET      = 16'd35000;
   localparam logic [31:0] MIN_PACKET          = 32'd5;
   localparam logic [15:0] MAX_PACKET_RESET    = 16'd35000;
   localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd32768;
   localparam int          QUEUE_DEPTH_DEFAULT = 4;

   // Configuration register indexes.
   localparam int          CSR_ADDR_W      = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_PACKET  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_PAYLOAD = 1'd1;

   // Request codes.
   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_CLOSE = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_CLOSED  = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_LENGTH = 3'd1;
   localparam logic [2:0] ERR_BAD_PAD    = 3'd2;
   localparam logic [2:0] ERR_TOO_LARGE  = 3'd3;
   localparam logic [2:0] ERR_INCOMPLETE = 3'd4;

   // Framing phase.
   typedef enum logic [2:0] {
      PH_LEN,
      PH_PADLEN,
      PH_PAYLOAD,
      PH_PADDING,
      PH_DISCARD,
      PH_STICKY
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  res_kind;
      logic [7:0]  out_byte;
      logic        last_payload;
      logic [15:0] payload_length;
      logic [2:0]  error_code;
   } rsp_item_type;

   // One queued entry: a first result, optionally followed by a done result.
   typedef struct packed {
      rsp_item_type res;
      logic         with_done;
      logic [15:0]  done_len;
   } spd_entry_type;

endpackage

// ===== sv/spd_front.sv =====
`timescale 1ns / 1ps
`include "ssh_packet_deframer_top_defines.svh"

module spd_front
   import spd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  req_item_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wdata,
   output logic                  q_push,
   output spd_entry_type         q_entry
);

   phase_type   phase_ff, phase_in;
   logic [31:0] length_accum_ff, length_accum_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic [15:0] payload_total_ff, payload_total_in;
   logic [15:0] max_packet_ff, max_payload_ff;

   logic        accept;
   logic        boundary;
   logic [15:0] limit;
   logic [31:0] accum_shift;
   logic [15:0] byte_ext;
   logic [15:0] bytes_dec;
   logic [15:0] payload_dec;
   logic [15:0] pay_len;

   assign accept      = req_push && !req_full;
   assign limit       = (max_packet_ff < ABS_MAX_PACKET) ? max_packet_ff : ABS_MAX_PACKET;
   assign accum_shift = {length_accum_ff[23:0], req_data.in_byte};
   assign byte_ext    = {8'd0, req_data.in_byte};
   assign bytes_dec   = bytes_left_ff - 16'd1;
   assign payload_dec = payload_left_ff - 16'd1;
   assign pay_len     = bytes_dec - byte_ext;
   assign boundary    = (phase_ff == PH_STICKY) ||
                        ((phase_ff == PH_LEN) && (header_count_ff == 2'd0));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff  <= MAX_PACKET_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MAX_PACKET:  max_packet_ff  <= csr_wdata;
            REG_MAX_PAYLOAD: max_payload_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Framing state and classification of each accepted byte.
   always_comb begin
      phase_in         = phase_ff;
      length_accum_in  = length_accum_ff;
      header_count_in  = header_count_ff;
      bytes_left_in    = bytes_left_ff;
      payload_left_in  = payload_left_ff;
      payload_total_in = payload_total_ff;
      q_push           = 1'b0;
      q_entry          = '0;

      if (accept) begin
         if (req_data.req_type == REQ_CLOSE) begin
            q_push = 1'b1;
            if (boundary) begin
               q_entry.res.res_kind = KIND_CLOSED;
            end else begin
               q_entry.res.res_kind   = KIND_ERROR;
               q_entry.res.error_code = ERR_INCOMPLETE;
            end
            phase_in         = PH_LEN;
            length_accum_in  = '0;
            header_count_in  = '0;
            bytes_left_in    = '0;
            payload_left_in  = '0;
            payload_total_in = '0;
         end else begin
            unique case (phase_ff)
               PH_PADLEN: begin
                  bytes_left_in = bytes_dec;
                  if (byte_ext >= bytes_dec) begin
                     phase_in               = PH_DISCARD;
                     q_push                 = 1'b1;
                     q_entry.res.res_kind   = KIND_ERROR;
                     q_entry.res.error_code = ERR_BAD_PAD;
                  end else if (pay_len > max_payload_ff) begin
                     phase_in               = PH_DISCARD;
                     q_push                 = 1'b1;
                     q_entry.res.res_kind   = KIND_ERROR;
                     q_entry.res.error_code = ERR_TOO_LARGE;
                  end else begin
                     payload_left_in  = pay_len;
                     payload_total_in = pay_len;
                     phase_in         = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  payload_left_in          = payload_dec;
                  bytes_left_in            = bytes_dec;
                  q_push                   = 1'b1;
                  q_entry.res.res_kind     = KIND_PAYLOAD;
                  q_entry.res.out_byte     = req_data.in_byte;
                  q_entry.res.last_payload = (payload_dec == 16'd0);
                  if (payload_dec == 16'd0) begin
                     if (bytes_dec == 16'd0) begin
                        // No padding: the done result follows the last byte.
                        q_entry.with_done = 1'b1;
                        q_entry.done_len  = payload_total_ff;
                        phase_in          = PH_LEN;
                        length_accum_in   = '0;
                        header_count_in   = '0;
                        bytes_left_in     = '0;
                        payload_left_in   = '0;
                        payload_total_in  = '0;
                     end else begin
                        phase_in = PH_PADDING;
                     end
                  end
               end
               PH_PADDING: begin
                  bytes_left_in = bytes_dec;
                  if (bytes_dec == 16'd0) begin
                     q_push                     = 1'b1;
                     q_entry.res.res_kind       = KIND_DONE;
                     q_entry.res.payload_length = payload_total_ff;
                     phase_in                   = PH_LEN;
                     length_accum_in            = '0;
                     header_count_in            = '0;
                     payload_left_in            = '0;
                     payload_total_in           = '0;
                  end
               end
               PH_DISCARD: begin
                  bytes_left_in = bytes_dec;
                  if (bytes_dec == 16'd0) begin
                     phase_in         = PH_LEN;
                     length_accum_in  = '0;
                     header_count_in  = '0;
                     payload_left_in  = '0;
                     payload_total_in = '0;
                  end
               end
               PH_STICKY: ;
               default: begin
                  // Gather the big-endian length, checked on its fourth byte.
                  phase_in = PH_LEN;
                  if (header_count_ff != 2'd3) begin
                     header_count_in = header_count_ff + 2'd1;
                     length_accum_in = accum_shift;
                  end else begin
                     header_count_in = '0;
                     length_accum_in = '0;
                     if ((accum_shift < MIN_PACKET) || (accum_shift > {16'd0, limit})) begin
                        phase_in               = PH_STICKY;
                        q_push                 = 1'b1;
                        q_entry.res.res_kind   = KIND_ERROR;
                        q_entry.res.error_code = ERR_BAD_LENGTH;
                     end else begin
                        bytes_left_in = accum_shift[15:0];
                        phase_in      = PH_PADLEN;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LEN;
         length_accum_ff  <= '0;
         header_count_ff  <= '0;
         bytes_left_ff    <= '0;
         payload_left_ff  <= '0;
         payload_total_ff <= '0;
      end else begin
         phase_ff         <= phase_in;
         length_accum_ff  <= length_accum_in;
         header_count_ff  <= header_count_in;
         bytes_left_ff    <= bytes_left_in;
         payload_left_ff  <= payload_left_in;
         payload_total_ff <= payload_total_in;
      end
   end

   // A combined entry always starts with the final payload byte.
   `SPD_ASSERT_NOW(a_done_follows_last, q_push && q_entry.with_done,
      (q_entry.res.res_kind == KIND_PAYLOAD) && q_entry.res.last_payload,
      "combined entry without a final payload byte")
   // The sticky error leaves no partial length behind.
   `SPD_ASSERT_NOW(a_sticky_clean, phase_ff == PH_STICKY,
      (header_count_ff == 2'd0) && (length_accum_ff == 32'd0),
      "partial length while in sticky error")
   // Nothing is queued while the queue reports full.
   `SPD_ASSERT_NOW(a_no_push_when_full, req_full, !q_push, "push while queue full")

endmodule

// ===== sv/spd_queue.sv =====
`timescale 1ns / 1ps

module spd_queue
   import spd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  spd_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output spd_entry_type pop_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   spd_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/spd_back.sv =====
`timescale 1ns / 1ps
`include "ssh_packet_deframer_top_defines.svh"

module spd_back
   import spd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  spd_entry_type q_data,
   output logic          q_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_item_type  rsp_data
);

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   logic         pending_done_ff, pending_done_in;
   logic [15:0]  pending_len_ff, pending_len_in;
   logic         load_en;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign load_en   = !out_valid_ff || rsp_pop;

   // Output register fill: a held done result goes first, then the queue.
   always_comb begin
      out_valid_in    = out_valid_ff;
      out_data_in     = out_data_ff;
      pending_done_in = pending_done_ff;
      pending_len_in  = pending_len_ff;
      q_pop           = 1'b0;
      if (load_en) begin
         priority if (pending_done_ff) begin
            out_valid_in               = 1'b1;
            out_data_in                = '0;
            out_data_in.res_kind       = KIND_DONE;
            out_data_in.payload_length = pending_len_ff;
            pending_done_in            = 1'b0;
         end else if (!q_empty) begin
            out_valid_in    = 1'b1;
            out_data_in     = q_data.res;
            pending_done_in = q_data.with_done;
            pending_len_in  = q_data.done_len;
            q_pop           = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         pending_done_ff <= 1'b0;
      end else begin
         out_valid_ff    <= out_valid_in;
         pending_done_ff <= pending_done_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff    <= out_data_in;
      pending_len_ff <= pending_len_in;
   end

   // A held done result always sits behind a visible final payload byte.
   `SPD_ASSERT_NOW(a_pending_has_byte, pending_done_ff,
      out_valid_ff && (out_data_ff.res_kind == KIND_PAYLOAD) && out_data_ff.last_payload,
      "done result held without its final payload byte")
   // The queue is not read while a done result is still held.
   `SPD_ASSERT_NOW(a_no_pop_while_pending, pending_done_ff, !q_pop,
      "queue read while done result pending")
   // Taking the final byte of a combined entry brings up the done result.
   `SPD_ASSERT_NEXT(a_done_after_byte, pending_done_ff && rsp_pop,
      out_valid_ff && (out_data_ff.res_kind == KIND_DONE),
      "done result missing after final payload byte")

endmodule

// ===== sv/ssh_packet_deframer_top.sv =====
`timescale 1ns / 1ps
// A result is queued when its byte is accepted, then loaded into the rsp result register.
// Throughput: one byte per cycle while the queue has room; the result register drains
// one result per cycle on rsp_pop; a final payload byte with no padding yields two results.
// A short queue between the framing logic and the result register absorbs stalls.
// Reset: synchronous, active high; framing state clears and the limits return to
// 35000 and 32768 on any clock edge with reset high.

module ssh_packet_deframer_top
   import spd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_item_type          req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_item_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wdata
);

   logic          q_push, q_pop, q_empty;
   spd_entry_type q_push_data, q_pop_data;

   spd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_entry   (q_push_data)
   );

   spd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   spd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
